/* rtl/fts_pkg.sv */
package fts_pkg;

  localparam int THREADS_DEF = 4;
  localparam int MUTEXES_DEF = 4;

  typedef enum logic [2:0] {
    OP_SPAWN  = 3'd0,
    OP_YIELD  = 3'd1,
    OP_LOCK   = 3'd2,
    OP_UNLOCK = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NO_READY  = 2'd2,
    ST_INIT_DONE = 2'd3
  } status_t;

  // one result word, as seen on the out_ ports
  typedef struct packed {
    logic [2:0] running;
    logic [2:0] spawned;
    logic       switched;
    status_t    status;
  } res_t;

endpackage

/* rtl/fifo_thread_scheduler_mutex.sv */
// Channel  | Ports                                           | Handshake
// ---------+-------------------------------------------------+---------------------------
// input    | in_op, in_mutex_id                              | start & !busy
// result   | out_running_thread, out_spawned_thread,         | out_valid, one cycle,
//          | out_switched, out_status                        | no back-pressure
//
// One word accepted per clock; busy never rises. Each word gives exactly one
// result word: the input register loads at the accepting edge, the next edge
// runs one update pass over the queue pointers into the result register, so
// out_valid is high in the cycle after that edge.
// Synchronous active-low reset: pool threads chained on the free list, thread 0
// running, all mutexes free, no output strobe. The receiver cannot stall.
module fifo_thread_scheduler_mutex
  import fts_pkg::*;
#(
  parameter int THREADS = THREADS_DEF,
  parameter int MUTEXES = MUTEXES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_op,
  input  logic [1:0] in_mutex_id,
  output logic       out_valid,
  output logic [2:0] out_running_thread,
  output logic [2:0] out_spawned_thread,
  output logic       out_switched,
  output logic [1:0] out_status
);

  // input stage
  logic       in_vld_r;
  op_t        op_r;
  logic [1:0] mutex_id_r;

  // result stage
  logic out_vld_r;
  res_t res_r;
  res_t res;

  // every cycle is a free slot: the core finishes a word per clock
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r       <= op_t'(in_op);
      mutex_id_r <= in_mutex_id;
    end
  end

  fts_core #(
    .THREADS (THREADS),
    .MUTEXES (MUTEXES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (in_vld_r),
    .op       (op_r),
    .mutex_id (mutex_id_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  // payload only; the strobe qualifies it
  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_running_thread = res_r.running;
  assign out_spawned_thread = res_r.spawned;
  assign out_switched       = res_r.switched;
  assign out_status         = res_r.status;

endmodule

/* rtl/fts_core.sv */
module fts_core
  import fts_pkg::*;
#(
  parameter int THREADS = THREADS_DEF,
  parameter int MUTEXES = MUTEXES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  op_t        op,
  input  logic [1:0] mutex_id,
  output res_t       res
);

  localparam int TW    = $clog2(THREADS + 2);
  localparam int LINKS = 1 << TW;
  localparam int MW    = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;
  localparam logic [TW-1:0] NIL = TW'(THREADS + 1);

  // queue state
  logic [TW-1:0] link_r [LINKS];
  logic [TW-1:0] free_head_r, free_tail_r;
  logic [TW-1:0] ready_head_r, ready_tail_r;
  logic [TW-1:0] running_r;
  logic          locked_r [MUTEXES];
  logic [TW-1:0] wait_head_r [MUTEXES];
  logic [TW-1:0] wait_tail_r [MUTEXES];

  logic [TW-1:0] link_nxt [LINKS];
  logic [TW-1:0] free_head_nxt, free_tail_nxt;
  logic [TW-1:0] ready_head_nxt, ready_tail_nxt;
  logic [TW-1:0] running_nxt;
  logic          locked_nxt [MUTEXES];
  logic [TW-1:0] wait_head_nxt [MUTEXES];
  logic [TW-1:0] wait_tail_nxt [MUTEXES];

  logic [TW-1:0] spawned;
  logic [TW-1:0] taken;
  logic [TW-1:0] waiter;
  status_t       status;
  logic          m_ok;
  logic [MW-1:0] mi;

  assign m_ok = (32'(mutex_id) < MUTEXES);
  assign mi   = MW'(mutex_id);

  // one pass over the queues; each enqueue/dequeue is a few pointer moves
  always_comb begin
    link_nxt       = link_r;
    free_head_nxt  = free_head_r;
    free_tail_nxt  = free_tail_r;
    ready_head_nxt = ready_head_r;
    ready_tail_nxt = ready_tail_r;
    running_nxt    = running_r;
    locked_nxt     = locked_r;
    wait_head_nxt  = wait_head_r;
    wait_tail_nxt  = wait_tail_r;
    spawned        = '0;
    taken          = '0;
    waiter         = '0;
    status         = ST_OK;

    unique case (op)
      OP_SPAWN: begin
        if (free_head_nxt == NIL) begin
          status = ST_NO_FREE;
        end else begin
          taken         = free_head_nxt;
          free_head_nxt = link_nxt[taken];
          if (free_head_nxt == NIL) free_tail_nxt = NIL;
          link_nxt[taken] = NIL;
          if (ready_head_nxt == NIL) ready_head_nxt = taken;
          else link_nxt[ready_tail_nxt] = taken;
          ready_tail_nxt = taken;
          spawned        = taken;
        end
      end
      OP_YIELD: begin
        // empty ready queue: the running thread comes straight back
        link_nxt[running_nxt] = NIL;
        if (ready_head_nxt == NIL) ready_head_nxt = running_nxt;
        else link_nxt[ready_tail_nxt] = running_nxt;
        ready_tail_nxt = running_nxt;
        taken          = ready_head_nxt;
        ready_head_nxt = link_nxt[taken];
        if (ready_head_nxt == NIL) ready_tail_nxt = NIL;
        running_nxt = taken;
      end
      OP_LOCK: begin
        if (m_ok) begin
          if (!locked_nxt[mi]) begin
            locked_nxt[mi] = 1'b1;
          end else if (ready_head_nxt == NIL) begin
            status = ST_NO_READY;
          end else begin
            link_nxt[running_nxt] = NIL;
            if (wait_head_nxt[mi] == NIL) wait_head_nxt[mi] = running_nxt;
            else link_nxt[wait_tail_nxt[mi]] = running_nxt;
            wait_tail_nxt[mi] = running_nxt;
            taken             = ready_head_nxt;
            ready_head_nxt    = link_nxt[taken];
            if (ready_head_nxt == NIL) ready_tail_nxt = NIL;
            running_nxt = taken;
          end
        end
      end
      OP_UNLOCK: begin
        if (m_ok) begin
          if (wait_head_nxt[mi] != NIL) begin
            // hand over to the first waiter; mutex stays locked
            waiter            = wait_head_nxt[mi];
            wait_head_nxt[mi] = link_nxt[waiter];
            if (wait_head_nxt[mi] == NIL) wait_tail_nxt[mi] = NIL;
            link_nxt[waiter] = NIL;
            if (ready_head_nxt == NIL) ready_head_nxt = waiter;
            else link_nxt[ready_tail_nxt] = waiter;
            ready_tail_nxt = waiter;
          end else begin
            locked_nxt[mi] = 1'b0;
          end
        end
      end
      OP_FINISH: begin
        if (running_nxt == '0) begin
          status = ST_INIT_DONE;
        end else if (ready_head_nxt == NIL) begin
          status = ST_NO_READY;
        end else begin
          link_nxt[running_nxt] = NIL;
          if (free_head_nxt == NIL) free_head_nxt = running_nxt;
          else link_nxt[free_tail_nxt] = running_nxt;
          free_tail_nxt  = running_nxt;
          taken          = ready_head_nxt;
          ready_head_nxt = link_nxt[taken];
          if (ready_head_nxt == NIL) ready_tail_nxt = NIL;
          running_nxt = taken;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.running  = 3'(running_nxt);
    res.spawned  = 3'(spawned);
    res.switched = (running_nxt != running_r);
    res.status   = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINKS; i++) begin
        link_r[i] <= (i >= 1 && i < THREADS) ? TW'(i + 1) : NIL;
      end
      free_head_r  <= TW'(1);
      free_tail_r  <= TW'(THREADS);
      ready_head_r <= NIL;
      ready_tail_r <= NIL;
      running_r    <= '0;
      for (int j = 0; j < MUTEXES; j++) begin
        locked_r[j]    <= 1'b0;
        wait_head_r[j] <= NIL;
        wait_tail_r[j] <= NIL;
      end
    end else if (go) begin
      link_r       <= link_nxt;
      free_head_r  <= free_head_nxt;
      free_tail_r  <= free_tail_nxt;
      ready_head_r <= ready_head_nxt;
      ready_tail_r <= ready_tail_nxt;
      running_r    <= running_nxt;
      locked_r     <= locked_nxt;
      wait_head_r  <= wait_head_nxt;
      wait_tail_r  <= wait_tail_nxt;
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

// Block-level bench for the FIFO thread scheduler with mutexes.
// A queue of command words is filled up front and fed to the block by a
// clocked driver. A shadow scheduler predicts one result word per accepted
// command, and a clocked monitor checks each strobed result against the
// oldest prediction.
module tb_top;
  import fts_pkg::*;

  localparam int NT      = THREADS_DEF;
  localparam int NM      = MUTEXES_DEF;
  localparam int NIL     = NT + 1;     // null link, as the block codes it
  localparam int SLOTS   = NT + 2;
  localparam int Q_FREE  = 0;          // queue indexes into the shadow head/tail arrays
  localparam int Q_READY = 1;
  localparam int Q_WAIT0 = 2;          // wait queue of mutex m sits at Q_WAIT0 + m
  localparam int NQ      = Q_WAIT0 + NM;
  localparam int N_RAND  = 1430;

  typedef struct {
    logic [2:0] op;
    logic [1:0] mid;
    bit         drain;   // hold this word back until no result is outstanding
  } cmd_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_op = '0;
  logic [1:0] in_mutex_id = '0;
  logic       out_valid;
  logic [2:0] out_running_thread;
  logic [2:0] out_spawned_thread;
  logic       out_switched;
  logic [1:0] out_status;

  cmd_word_t cmd_q[$];        // commands not yet accepted
  res_t      sched_res_q[$];  // predicted result words, oldest first
  int        mismatches = 0;
  int        n_accepted = 0;

  // shadow scheduler state
  logic [2:0] link_nxt [SLOTS];
  logic [2:0] q_head   [NQ];
  logic [2:0] q_tail   [NQ];
  logic [2:0] run_thr;
  logic       mtx_held [NM];

  fifo_thread_scheduler_mutex i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_mutex_id       (in_mutex_id),
    .out_valid         (out_valid),
    .out_running_thread(out_running_thread),
    .out_spawned_thread(out_spawned_thread),
    .out_switched      (out_switched),
    .out_status        (out_status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow scheduler
  // ---------------------------------------------------------------------

  // pool threads chained on the free list, thread 0 running, all else empty
  function automatic void sched_reset();
    for (int i = 0; i < SLOTS; i++) link_nxt[i] = 3'(NIL);
    for (int i = 1; i < NT; i++) link_nxt[i] = 3'(i + 1);
    for (int q = 0; q < NQ; q++) begin
      q_head[q] = 3'(NIL);
      q_tail[q] = 3'(NIL);
    end
    q_head[Q_FREE] = 3'd1;
    q_tail[Q_FREE] = 3'(NT);
    run_thr = '0;
    for (int m = 0; m < NM; m++) mtx_held[m] = 1'b0;
  endfunction

  function automatic void thr_append(int qid, logic [2:0] t);
    link_nxt[t] = 3'(NIL);
    if (q_head[qid] == 3'(NIL)) q_head[qid] = t;
    else link_nxt[q_tail[qid]] = t;
    q_tail[qid] = t;
  endfunction

  // caller makes sure the queue is not empty
  function automatic logic [2:0] thr_pop(int qid);
    logic [2:0] t;
    t = q_head[qid];
    q_head[qid] = link_nxt[t];
    if (q_head[qid] == 3'(NIL)) q_tail[qid] = 3'(NIL);
    return t;
  endfunction

  // one scheduler event: update the shadow state, return the result word
  function automatic res_t sched_predict(logic [2:0] op, logic [1:0] mid);
    res_t       r;
    logic [2:0] prev_run;
    logic [2:0] spawned;
    status_t    st;
    int         m;
    prev_run = run_thr;
    spawned  = '0;
    st       = ST_OK;
    m        = int'(mid);
    case (op)
      OP_SPAWN: begin
        if (q_head[Q_FREE] == 3'(NIL)) begin
          st = ST_NO_FREE;
        end else begin
          spawned = thr_pop(Q_FREE);
          thr_append(Q_READY, spawned);
        end
      end
      OP_YIELD: begin
        // with nothing ready the running thread goes out and straight back in
        thr_append(Q_READY, run_thr);
        run_thr = thr_pop(Q_READY);
      end
      OP_LOCK: begin
        if (m < NM) begin
          if (!mtx_held[m]) begin
            mtx_held[m] = 1'b1;
          end else if (q_head[Q_READY] == 3'(NIL)) begin
            st = ST_NO_READY;
          end else begin
            thr_append(Q_WAIT0 + m, run_thr);
            run_thr = thr_pop(Q_READY);
          end
        end
      end
      OP_UNLOCK: begin
        // hand-over to the first waiter; no owner check
        if (m < NM) begin
          if (q_head[Q_WAIT0 + m] != 3'(NIL)) thr_append(Q_READY, thr_pop(Q_WAIT0 + m));
          else mtx_held[m] = 1'b0;
        end
      end
      OP_FINISH: begin
        // initial-thread check takes priority over the ready check
        if (run_thr == 3'd0) begin
          st = ST_INIT_DONE;
        end else if (q_head[Q_READY] == 3'(NIL)) begin
          st = ST_NO_READY;
        end else begin
          thr_append(Q_FREE, run_thr);
          run_thr = thr_pop(Q_READY);
        end
      end
      default: ;  // undefined codes are ignored
    endcase
    r.running  = run_thr;
    r.spawned  = spawned;
    r.switched = (run_thr != prev_run);
    r.status   = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents the head of cmd_q, predicts on acceptance
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drv
    bit quiet;
    bit go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        sched_res_q.push_back(sched_predict(in_op, in_mutex_id));
        void'(cmd_q.pop_front());
        n_accepted++;
      end
      // a stretch in the middle runs back to back
      quiet = (n_accepted >= 600 && n_accepted < 900);
      go = (cmd_q.size() != 0) && (quiet || $urandom_range(0, 99) >= 23);
      if (go && cmd_q[0].drain && sched_res_q.size() != 0) go = 1'b0;
      if (go) begin
        start       <= 1'b1;
        in_op       <= cmd_q[0].op;
        in_mutex_id <= cmd_q[0].mid;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobed result word against the oldest prediction
  // ---------------------------------------------------------------------
  task automatic chk_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : mon
    res_t e;
    if (rst_n && out_valid) begin
      if (sched_res_q.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected: expected none, got %0d/%0d/%0d/%0d",
                 $time, out_running_thread, out_spawned_thread, out_switched, out_status);
      end else begin
        e = sched_res_q.pop_front();
        chk_field("running_thread", e.running, out_running_thread);
        chk_field("spawned_thread", e.spawned, out_spawned_thread);
        chk_field("switched", e.switched, out_switched);
        chk_field("status", e.status, out_status);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic add_cmd(logic [2:0] op, logic [1:0] mid, bit drain = 1'b0);
    cmd_word_t w;
    w.op    = op;
    w.mid   = mid;
    w.drain = drain;
    cmd_q.push_back(w);
  endtask

  initial begin
    logic [2:0] op;
    logic [1:0] mid;
    int         pick;
    sched_reset();

    // directed: corner cases first, on a freshly reset scheduler
    add_cmd(OP_FINISH, 2'd0);   // initial thread may not finish
    add_cmd(OP_YIELD,  2'd0);   // nothing ready, thread 0 keeps running
    add_cmd(OP_LOCK,   2'd0);   // takes free mutex
    add_cmd(OP_LOCK,   2'd0);   // would block, nothing ready
    add_cmd(OP_UNLOCK, 2'd3);   // unlock of a free mutex
    repeat (NT) add_cmd(OP_SPAWN, 2'd1);
    add_cmd(OP_SPAWN,  2'd2);   // free list exhausted
    add_cmd(OP_LOCK,   2'd0);   // thread 0 parks on mutex 0
    add_cmd(OP_LOCK,   2'd3);
    add_cmd(OP_LOCK,   2'd3);   // second waiter, on mutex 3
    add_cmd(OP_FINISH, 2'd0);   // pool thread back to the free list
    add_cmd(OP_UNLOCK, 2'd0);   // hand-over to thread 0
    add_cmd(OP_UNLOCK, 2'd3);   // hand-over
    add_cmd(OP_UNLOCK, 2'd3);   // now really freed
    add_cmd(3'd5, 2'd3);        // undefined codes
    add_cmd(3'd6, 2'd0);
    add_cmd(3'd7, 2'd3);
    add_cmd(OP_YIELD,  2'd2);
    add_cmd(OP_FINISH, 2'd1);
    add_cmd(OP_FINISH, 2'd2);
    add_cmd(OP_FINISH, 2'd3);
    add_cmd(OP_YIELD,  2'd0, 1'b1);

    // random: mostly sensible traffic; mutexes 0 and 1 hot to build wait queues
    for (int i = 0; i < N_RAND; i++) begin
      pick = $urandom_range(0, 99);
      mid  = ($urandom_range(0, 1) != 0) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 3));
      if      (pick < 20) op = OP_SPAWN;
      else if (pick < 42) op = OP_YIELD;
      else if (pick < 64) op = OP_LOCK;
      else if (pick < 84) op = OP_UNLOCK;
      else if (pick < 96) op = OP_FINISH;
      else                op = 3'($urandom_range(5, 7));
      // occasionally let the pipe run dry before the next word
      add_cmd(op, mid, (i == 400) || (i == 1100) || ($urandom_range(0, 199) == 0));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0) @(posedge clk);
    for (int g = 0; g < 1000 && sched_res_q.size() != 0; g++) @(posedge clk);
    if (sched_res_q.size() != 0) begin
      mismatches++;
      $display("%0t: results outstanding at end: expected 0, got %0d",
               $time, sched_res_q.size());
    end
    // give any stray strobe time to show up
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS fifo_thread_scheduler_mutex");
    end else begin
      $display("FAIL fifo_thread_scheduler_mutex");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL fifo_thread_scheduler_mutex");
    $finish;
  end

endmodule

/* sim.f */
rtl/fts_pkg.sv
rtl/fts_core.sv
rtl/fifo_thread_scheduler_mutex.sv
verif/tb_top.sv
